>>> design/rat_pkg.sv
// ----------------------------------------------------------------------------
// rat_pkg
// Shared widths, operation codes and sequencer states of the rational ALU.
// ----------------------------------------------------------------------------
package rat_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_WIDTH     = 2 * OPERAND_WIDTH + 1;
    localparam int DEN_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int MAG_WIDTH     = NUM_WIDTH;
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH + 1);

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } state_t;

endpackage

>>> design/rational_alu_with_reduction.sv
// ----------------------------------------------------------------------------
// rational_alu_with_reduction
// Signed fraction add/sub/mul/div with gcd reduction on a shared divider.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Products are formed on one shared 16x16
// multiplier in ST_MUL0 and ST_MUL1, and for add and subtract also ST_MUL2.
// The reduction runs Euclid on a one-bit-per-cycle divider, one division per
// remainder step, then two exact divisions by the gcd, first of the numerator
// and then of the denominator. A zero denominator skips the reduction.
// s_tready is high only when idle, and idle returns in the cycle after the
// result beat is taken.
module rational_alu_with_reduction
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], x_num[17:2], x_den[33:18], y_num[49:34], y_den[65:50]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // raw_num[32:0], raw_den[64:33], red_num[97:65], red_den[129:98]
    output logic [135:0] m_tdata,
    // zero_den[0]
    output logic        m_tuser
);

    localparam int OW = rat_pkg::OPERAND_WIDTH;
    localparam int NW = rat_pkg::NUM_WIDTH;
    localparam int DW = rat_pkg::DEN_WIDTH;
    localparam int MW = rat_pkg::MAG_WIDTH;

    rat_pkg::state_t state_reg, state_next;

    logic [1:0]             func_reg;
    logic signed [OW-1:0]   xn_reg, xd_reg, yn_reg, yd_reg;
    logic signed [DW-1:0]   p0_reg, p1_reg;
    logic signed [NW-1:0]   rn_reg;
    logic signed [DW-1:0]   rd_reg;
    logic signed [NW-1:0]   qn_reg;
    logic signed [DW-1:0]   qd_reg;
    logic                   zero_reg;
    logic [MW-1:0]          a_reg, b_reg;
    logic                   div_wait_reg;

    logic signed [OW-1:0]   ma, mb;
    logic signed [DW-1:0]   prod;
    logic                   div_start, div_done;
    logic [MW-1:0]          div_a, div_b, div_q, div_r;
    logic [MW-1:0]          mag_n, mag_d;
    logic signed [NW-1:0]   comb_n;

    assign mag_n = rn_reg[NW-1] ? MW'(-rn_reg) : MW'(rn_reg);
    assign mag_d = rd_reg[DW-1] ? MW'(-{rd_reg[DW-1], rd_reg}) : MW'({1'b0, rd_reg});

    always_comb
    begin
        ma = xn_reg;
        mb = yd_reg;
        unique case (state_reg)
            rat_pkg::ST_MUL0:
            begin
                ma = xn_reg;
                mb = (func_reg == rat_pkg::FUNC_MUL) ? yn_reg : yd_reg;
            end
            rat_pkg::ST_MUL1:
            begin
                ma = (func_reg == rat_pkg::FUNC_MUL) ? xd_reg : yn_reg;
                mb = (func_reg == rat_pkg::FUNC_MUL) ? yd_reg : xd_reg;
            end
            rat_pkg::ST_MUL2:
            begin
                ma = xd_reg;
                mb = yd_reg;
            end
            default:
            begin
                ma = xn_reg;
                mb = yd_reg;
            end
        endcase
    end

    assign prod = DW'(ma) * DW'(mb);

    always_comb
    begin
        unique case (rat_pkg::func_t'(func_reg))
            rat_pkg::FUNC_ADD: comb_n = NW'(p0_reg) + NW'(p1_reg);
            rat_pkg::FUNC_SUB: comb_n = NW'(p0_reg) - NW'(p1_reg);
            default:           comb_n = NW'(p0_reg);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rat_pkg::ST_IDLE: if (s_tvalid) state_next = rat_pkg::ST_MUL0;
            rat_pkg::ST_MUL0: state_next = rat_pkg::ST_MUL1;
            rat_pkg::ST_MUL1: state_next = (func_reg == rat_pkg::FUNC_ADD ||
                                            func_reg == rat_pkg::FUNC_SUB) ?
                                           rat_pkg::ST_MUL2 : rat_pkg::ST_COMB;
            rat_pkg::ST_MUL2: state_next = rat_pkg::ST_COMB;
            rat_pkg::ST_COMB: state_next = (p1_reg == '0 && func_reg != rat_pkg::FUNC_ADD &&
                                            func_reg != rat_pkg::FUNC_SUB) ||
                                           (rd_reg == '0 && (func_reg == rat_pkg::FUNC_ADD ||
                                            func_reg == rat_pkg::FUNC_SUB)) ?
                                           rat_pkg::ST_OUT : rat_pkg::ST_GCD;
            rat_pkg::ST_GCD:  if (!div_wait_reg && b_reg == '0) state_next = rat_pkg::ST_DIVN;
            rat_pkg::ST_DIVN: if (div_done) state_next = rat_pkg::ST_DIVD;
            rat_pkg::ST_DIVD: if (div_done) state_next = rat_pkg::ST_OUT;
            rat_pkg::ST_OUT:  if (m_tready) state_next = rat_pkg::ST_IDLE;
            default:          state_next = rat_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == rat_pkg::ST_IDLE);
        m_tvalid  = (state_reg == rat_pkg::ST_OUT);
        div_start = 1'b0;
        div_a     = a_reg;
        div_b     = b_reg;
        if (state_reg == rat_pkg::ST_GCD && !div_wait_reg && b_reg != '0)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == rat_pkg::ST_GCD && !div_wait_reg && b_reg == '0)
        begin
            div_start = 1'b1;
            div_a     = mag_n;
            div_b     = a_reg;
        end
        else if (state_reg == rat_pkg::ST_DIVN && div_done)
        begin
            div_start = 1'b1;
            div_a     = mag_d;
            div_b     = a_reg;
        end
    end

    rat_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rat_pkg::ST_IDLE;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start && state_reg == rat_pkg::ST_GCD && b_reg != '0)
            begin
                div_wait_reg <= 1'b1;
            end
            else if (div_done)
            begin
                div_wait_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rat_pkg::ST_IDLE:
            begin
                func_reg <= s_tdata[1:0];
                xn_reg   <= s_tdata[2 +: OW];
                xd_reg   <= s_tdata[2 + OW +: OW];
                yn_reg   <= s_tdata[2 + 2 * OW +: OW];
                yd_reg   <= s_tdata[2 + 3 * OW +: OW];
            end
            rat_pkg::ST_MUL0: p0_reg <= prod;
            rat_pkg::ST_MUL1: p1_reg <= prod;
            rat_pkg::ST_MUL2: rd_reg <= prod;
            rat_pkg::ST_COMB:
            begin
                rn_reg <= comb_n;
                if (func_reg != rat_pkg::FUNC_ADD && func_reg != rat_pkg::FUNC_SUB)
                begin
                    rd_reg <= p1_reg;
                    zero_reg <= (p1_reg == '0);
                    a_reg <= comb_n[NW-1] ? MW'(-comb_n) : MW'(comb_n);
                    b_reg <= p1_reg[DW-1] ? MW'(-{p1_reg[DW-1], p1_reg}) :
                                            MW'({1'b0, p1_reg});
                end
                else
                begin
                    zero_reg <= (rd_reg == '0);
                    a_reg <= comb_n[NW-1] ? MW'(-comb_n) : MW'(comb_n);
                    b_reg <= mag_d;
                end
                qn_reg <= '0;
                qd_reg <= '0;
            end
            rat_pkg::ST_GCD:
            begin
                if (div_wait_reg && div_done)
                begin
                    a_reg <= b_reg;
                    b_reg <= div_r;
                end
            end
            rat_pkg::ST_DIVN: if (div_done) qn_reg <= rn_reg[NW-1] ? -NW'(div_q) : NW'(div_q);
            rat_pkg::ST_DIVD: if (div_done) qd_reg <= rd_reg[DW-1] ? -DW'(div_q) : DW'(div_q);
            default:
            begin
            end
        endcase
    end

    assign m_tdata = {6'd0, qd_reg, qn_reg, rd_reg, rn_reg};
    assign m_tuser = zero_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_zero_red: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (qn_reg == '0 && qd_reg == '0))
        else $error("zero denominator not cleared");
`endif

endmodule

>>> design/rat_divider.sv
// ----------------------------------------------------------------------------
// rat_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rat_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rat_pkg::MAG_WIDTH-1:0]     dividend,
    input  logic [rat_pkg::MAG_WIDTH-1:0]     divisor,
    output logic                              done,
    output logic [rat_pkg::MAG_WIDTH-1:0]     quotient,
    output logic [rat_pkg::MAG_WIDTH-1:0]     remainder
);

    localparam int W = rat_pkg::MAG_WIDTH;

    logic [W-1:0]                   q_reg, q_next;
    logic [W-1:0]                   r_reg, r_next;
    logic [W-1:0]                   d_reg;
    logic [rat_pkg::CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [W:0]                     trial;

    always_comb
    begin
        trial     = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = rat_pkg::CNT_WIDTH'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rat_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider busy at done");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider count underflow");
`endif

endmodule

>>> bench/rational_alu_with_reduction_check.sv
// ----------------------------------------------------------------------------
// rational_alu_with_reduction_check
// Watches both stream channels, computes the expected unreduced and
// gcd-reduced fraction for every accepted input beat, and compares each
// output beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rational_alu_with_reduction_check
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tuser,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [rat_pkg::NUM_WIDTH-1:0] raw_num;
        logic [rat_pkg::DEN_WIDTH-1:0] raw_den;
        logic [rat_pkg::NUM_WIDTH-1:0] red_num;
        logic [rat_pkg::DEN_WIDTH-1:0] red_den;
        logic                          zero_den;
    } fraction_t;

    fraction_t fractions_due[$];

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic fraction_t reduce_fraction(logic [71:0] word);
        fraction_t       f;
        rat_pkg::func_t  op;
        longint          xn, xd, yn, yd, rn, rd, g;
        op = rat_pkg::func_t'(word[1:0]);
        xn = longint'($signed(word[17:2]));
        xd = longint'($signed(word[33:18]));
        yn = longint'($signed(word[49:34]));
        yd = longint'($signed(word[65:50]));
        case (op)
            rat_pkg::FUNC_ADD: begin rn = xn * yd + yn * xd; rd = xd * yd; end
            rat_pkg::FUNC_SUB: begin rn = xn * yd - yn * xd; rd = xd * yd; end
            rat_pkg::FUNC_MUL: begin rn = xn * yn;           rd = xd * yd; end
            default:           begin rn = xn * yd;           rd = yn * xd; end
        endcase
        f.raw_num  = rn[rat_pkg::NUM_WIDTH-1:0];
        f.raw_den  = rd[rat_pkg::DEN_WIDTH-1:0];
        f.zero_den = (rd == 0);
        f.red_num  = '0;
        f.red_den  = '0;
        if (rd != 0)
        begin
            g = longint'(gcd_of(rn < 0 ? -rn : rn, rd < 0 ? -rd : rd));
            rn = rn / g;
            rd = rd / g;
            f.red_num = rn[rat_pkg::NUM_WIDTH-1:0];
            f.red_den = rd[rat_pkg::DEN_WIDTH-1:0];
        end
        return f;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        fraction_t e;
        fraction_t a;
        if (rst_n && s_tvalid && s_tready)
            fractions_due.push_back(reduce_fraction(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            a.raw_num  = m_tdata[32:0];
            a.raw_den  = m_tdata[64:33];
            a.red_num  = m_tdata[97:65];
            a.red_den  = m_tdata[129:98];
            a.zero_den = m_tuser;
            if (fractions_due.size() == 0)
            begin
                $display("%0t: unexpected beat raw %h/%h", $realtime, a.raw_num, a.raw_den);
                errors++;
            end
            else
            begin
                e = fractions_due.pop_front();
                if (a.raw_num !== e.raw_num)
                begin
                    $display("%0t: raw_num exp %h got %h", $realtime, e.raw_num, a.raw_num);
                    errors++;
                end
                if (a.raw_den !== e.raw_den)
                begin
                    $display("%0t: raw_den exp %h got %h", $realtime, e.raw_den, a.raw_den);
                    errors++;
                end
                if (a.red_num !== e.red_num)
                begin
                    $display("%0t: red_num exp %h got %h", $realtime, e.red_num, a.red_num);
                    errors++;
                end
                if (a.red_den !== e.red_den)
                begin
                    $display("%0t: red_den exp %h got %h", $realtime, e.red_den, a.red_den);
                    errors++;
                end
                if (a.zero_den !== e.zero_den)
                begin
                    $display("%0t: zero_den exp %b got %b", $realtime, e.zero_den, a.zero_den);
                    errors++;
                end
            end
        end
        pending = fractions_due.size();
    end

endmodule

>>> bench/rational_alu_with_reduction_test.sv
// ----------------------------------------------------------------------------
// rational_alu_with_reduction_test
// Drives directed extremes and random fraction pairs through the rational
// ALU with random gaps and output stalls; the checker judges every beat.
// ----------------------------------------------------------------------------
module rational_alu_with_reduction_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tuser;
    int           errors;
    int           pending;

    localparam logic [15:0] MAXV = 16'h7fff;
    localparam logic [15:0] MINV = 16'h8000;

    rational_alu_with_reduction DUT (.*);

    rational_alu_with_reduction_check checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            n = gap_len();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
        end
    end

    task automatic send(rat_pkg::func_t op, logic [15:0] xn, logic [15:0] xd,
                        logic [15:0] yn, logic [15:0] yd);
        int n;
        s_tdata  <= {6'b0, yd, yn, xd, xn, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        n = gap_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($signed($urandom_range(0, 40)) - 20);
        if (r == 4) return ($urandom_range(0, 1)) ? MAXV : MINV;
        if (r == 5) return 16'd0;
        return 16'($urandom);
    endfunction

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < 4; k++)
        begin
            send(rat_pkg::func_t'(k), MINV, MINV, MINV, MINV);
            send(rat_pkg::func_t'(k), MAXV, MAXV, MAXV, MAXV);
            send(rat_pkg::func_t'(k), MINV, MAXV, MAXV, MINV);
            send(rat_pkg::func_t'(k), 16'd3, 16'd0, 16'd5, 16'd7);
        end
        send(rat_pkg::FUNC_MUL, 16'd0, 16'd6, 16'd4, 16'hfffd);
        send(rat_pkg::FUNC_DIV, 16'd5, 16'd6, 16'd0, 16'd9);
        send(rat_pkg::FUNC_SUB, 16'd2, 16'd3, 16'd2, 16'd3);
        send(rat_pkg::FUNC_ADD, 16'd1, 16'hfffe, 16'd1, 16'd2);
        send(rat_pkg::FUNC_MUL, 16'hfffc, 16'd6, 16'd9, 16'hfff6);
        send(rat_pkg::FUNC_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        repeat (530)
            send(rat_pkg::func_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                 pick_operand(), pick_operand());

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (2000) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
